// ===== hw/rtl/mmr_pkg.sv =====
package mmr_pkg;

  // status byte constants
  localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
  localparam logic [7:0] STATUS_FIRST  = 8'h80;
  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;

  // command nibbles
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_CTRL     = 4'hB;
  localparam logic [3:0] CMD_BEND     = 4'hE;

  // routing word and field widths
  localparam int ROUTE_W   = 27;
  localparam int SLOT_W    = 3;
  localparam int REG_IDX_W = 3;

  localparam logic [15:0] BEND_CENTER = 16'd8192;

  typedef enum logic [2:0] {
    KIND_TICK = 3'd0,
    KIND_PLAY = 3'd1,
    KIND_STOP = 3'd2,
    KIND_CTRL = 3'd3,
    KIND_BEND = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } parse_phase_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pending;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/mmr_ctrl.sv =====
module mmr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mmr_pkg::dp_status_t status,
  output mmr_pkg::dp_cmd_t    cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_BUSY;
        end
        ST_BUSY: begin
          if (!status.pending) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // handshake and commands
  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.take_byte = (state == ST_IDLE) && in_valid;
    cmd.emit      = (state == ST_BUSY) && status.pending && status.out_free;
  end

endmodule

// ===== hw/rtl/mmr_datapath.sv =====
module mmr_datapath #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mmr_pkg::dp_cmd_t                     cmd,
  output mmr_pkg::dp_status_t                  status,
  input  logic [7:0]                           rx_byte,
  input  logic                                 cfg_write,
  input  logic [mmr_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [mmr_pkg::ROUTE_W-1:0]          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           event_kind,
  output logic [mmr_pkg::SLOT_W-1:0]           slot_index,
  output logic signed [8:0]                    out_key,
  output logic [7:0]                           out_velocity,
  output logic [7:0]                           controller_id,
  output logic [7:0]                           controller_value,
  output logic signed [15:0]                   bend_offset,
  output logic                                 last_of_run
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [mmr_pkg::ROUTE_W-1:0] route_word [SLOT_COUNT];

  mmr_pkg::parse_phase_t phase;
  logic [3:0]            held_channel;
  logic [3:0]            held_command;
  logic [7:0]            held_first_data;
  logic [7:0]            held_second;
  logic                  tick_pending;
  logic [SLOT_COUNT-1:0] slot_mask;
  logic [SLOT_COUNT-1:0] match_next;

  // routing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) route_word[i] <= '0;
    end else if (cfg_write && (32'(cfg_index) < SLOT_COUNT)) begin
      route_word[cfg_index[IDX_W-1:0]] <= cfg_data;
    end
  end

  // per-slot match against the held message
  always_comb begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      logic       en;
      logic [3:0] note_ch;
      logic [3:0] ctrl_ch;
      logic [6:0] lo_key;
      logic [6:0] hi_key;
      en      = route_word[s][0];
      note_ch = route_word[s][4:1];
      ctrl_ch = route_word[s][8:5];
      lo_key  = route_word[s][15:9];
      hi_key  = route_word[s][22:16];
      case (held_command)
        mmr_pkg::CMD_NOTE_OFF, mmr_pkg::CMD_NOTE_ON:
          match_next[s] = en && (note_ch == held_channel) &&
                          (held_first_data >= {1'b0, lo_key}) &&
                          (held_first_data <= {1'b0, hi_key});
        mmr_pkg::CMD_CTRL: match_next[s] = en && (ctrl_ch == held_channel);
        mmr_pkg::CMD_BEND: match_next[s] = en && (note_ch == held_channel);
        default:           match_next[s] = 1'b0;
      endcase
    end
  end

  // lowest pending slot
  logic [IDX_W-1:0]      sel;
  logic [SLOT_COUNT-1:0] mask_after;
  always_comb begin
    sel = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_mask[i]) sel = IDX_W'(i);
    end
    mask_after      = slot_mask;
    mask_after[sel] = 1'b0;
  end

  // fields of the selected slot
  logic [mmr_pkg::ROUTE_W-1:0] sel_word;
  logic signed [8:0]           trans9;
  logic signed [8:0]           key_calc;
  logic [7:0]                  vel_calc;
  logic [15:0]                 bend_raw;
  mmr_pkg::event_kind_t        kind_calc;
  always_comb begin
    sel_word = route_word[sel];
    trans9   = {{5{sel_word[26]}}, sel_word[26:23]};
    key_calc = $signed({1'b0, held_first_data}) + (trans9 <<< 3) + (trans9 <<< 2);
    vel_calc = (held_command == mmr_pkg::CMD_NOTE_OFF) ? 8'd0 : held_second;
    bend_raw = {1'b0, held_second, 7'b0} | {8'b0, held_first_data};
    case (held_command)
      mmr_pkg::CMD_CTRL: kind_calc = mmr_pkg::KIND_CTRL;
      mmr_pkg::CMD_BEND: kind_calc = mmr_pkg::KIND_BEND;
      default: kind_calc = (vel_calc == 8'd0) ? mmr_pkg::KIND_STOP : mmr_pkg::KIND_PLAY;
    endcase
  end

  // parser and pending run
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mmr_pkg::PH_STATUS;
      held_channel    <= '0;
      held_command    <= '0;
      held_first_data <= '0;
      tick_pending    <= 1'b0;
      slot_mask       <= '0;
    end else if (cmd.take_byte) begin
      if (rx_byte == mmr_pkg::BYTE_CLOCK) begin
        tick_pending <= 1'b1;
      end else begin
        case (phase)
          mmr_pkg::PH_FIRST: begin
            held_first_data <= rx_byte;
            phase           <= mmr_pkg::PH_SECOND;
          end
          mmr_pkg::PH_SECOND: begin
            held_second <= rx_byte;
            slot_mask   <= match_next;
            phase       <= mmr_pkg::PH_STATUS;
          end
          default: begin
            if (rx_byte >= mmr_pkg::STATUS_FIRST && rx_byte < mmr_pkg::STATUS_SYSTEM) begin
              held_channel <= rx_byte[3:0];
              held_command <= rx_byte[7:4];
              phase        <= mmr_pkg::PH_FIRST;
            end else begin
              phase <= mmr_pkg::PH_STATUS;
            end
          end
        endcase
      end
    end else if (cmd.emit) begin
      if (tick_pending) tick_pending <= 1'b0;
      else              slot_mask    <= mask_after;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_key          <= '0;
      out_velocity     <= '0;
      controller_id    <= '0;
      controller_value <= '0;
      bend_offset      <= '0;
      if (tick_pending) begin
        event_kind  <= mmr_pkg::KIND_TICK;
        slot_index  <= '0;
        last_of_run <= 1'b1;
      end else begin
        event_kind  <= kind_calc;
        slot_index  <= mmr_pkg::SLOT_W'(sel);
        last_of_run <= (mask_after == '0);
        case (kind_calc)
          mmr_pkg::KIND_PLAY: begin
            out_key      <= key_calc;
            out_velocity <= vel_calc;
          end
          mmr_pkg::KIND_STOP: out_key <= key_calc;
          mmr_pkg::KIND_CTRL: begin
            controller_id    <= held_first_data;
            controller_value <= held_second;
          end
          mmr_pkg::KIND_BEND: bend_offset <= $signed(bend_raw - mmr_pkg::BEND_CENTER);
          default: ;
        endcase
      end
    end
  end

  // status to controller
  always_comb begin
    status.pending  = tick_pending || (slot_mask != '0);
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ===== hw/rtl/midi_message_router.sv =====
// channel   handshake            payload
// in        in_valid/in_ready    rx_byte
// out       out_valid/out_ready  event_kind slot_index out_key out_velocity
//                                controller_id controller_value bend_offset last_of_run
// cfg       cfg_write            cfg_index cfg_data
//
// a byte is taken in idle, then busy emits its results, if any, and returns to idle
// the slot scan emits one result per cycle while the output register is free, from a registered match mask
// the next byte is taken once the run is finished, even if the last result waits
// rst is synchronous and clears the parser, routing words and output valid
// a stall on out holds the run in place until the result register frees up
module midi_message_router #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    event_kind,
  output logic [mmr_pkg::SLOT_W-1:0]    slot_index,
  output logic signed [8:0]             out_key,
  output logic [7:0]                    out_velocity,
  output logic [7:0]                    controller_id,
  output logic [7:0]                    controller_value,
  output logic signed [15:0]            bend_offset,
  output logic                          last_of_run,
  input  logic                          cfg_write,
  input  logic [mmr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mmr_pkg::ROUTE_W-1:0]   cfg_data
);

  mmr_pkg::dp_cmd_t    cmd;
  mmr_pkg::dp_status_t status;

  mmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mmr_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .rx_byte          (rx_byte),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_kind       (event_kind),
    .slot_index       (slot_index),
    .out_key          (out_key),
    .out_velocity     (out_velocity),
    .controller_id    (controller_id),
    .controller_value (controller_value),
    .bend_offset      (bend_offset),
    .last_of_run      (last_of_run)
  );

  // an accepted byte always starts a busy period
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a byte was taken");

  // more results of the run still to come
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_run) |=> !in_ready)
    else $error("input ready while a run is unfinished");

  // a tick is a run of one addressed to slot zero
  a_tick_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == mmr_pkg::KIND_TICK) |-> (last_of_run && slot_index == '0))
    else $error("malformed tick result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOT_COUNT    = 8;
  localparam int SETTLE_CYCLES = 2 * (SLOT_COUNT + 2);
  localparam int CYCLE_LIMIT   = 500000;

  // command nibbles that the router consumes without a result
  localparam logic [3:0] CMD_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] CMD_PROGRAM       = 4'hC;
  localparam logic [3:0] CMD_CHAN_PRESSURE = 4'hD;

  typedef struct {
    mmr_pkg::event_kind_t kind;
    logic [2:0]        slot;
    logic signed [8:0] key;
    logic [7:0]        velocity;
    logic [7:0]        ctrl_id;
    logic [7:0]        ctrl_value;
    logic signed [15:0] bend;
    logic              last_flag;
  } router_event_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic out_ready = 1'b0;
  logic cfg_write = 1'b0;
  logic [mmr_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [mmr_pkg::ROUTE_W-1:0] cfg_data = '0;

  wire in_ready;
  wire out_valid;
  wire [2:0] event_kind;
  wire [mmr_pkg::SLOT_W-1:0] slot_index;
  wire signed [8:0] out_key;
  wire [7:0] out_velocity;
  wire [7:0] controller_id;
  wire [7:0] controller_value;
  wire signed [15:0] bend_offset;
  wire last_of_run;

  // predictor state
  logic [mmr_pkg::ROUTE_W-1:0] route_copy [SLOT_COUNT];
  mmr_pkg::parse_phase_t phase_copy = mmr_pkg::PH_STATUS;
  logic [3:0] chan_copy = 4'h0;
  logic [3:0] cmd_copy = 4'h0;
  logic [7:0] first_copy = 8'h00;

  router_event_t expected_events [$];
  int errors = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  midi_message_router #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .slot_index(slot_index),
    .out_key(out_key),
    .out_velocity(out_velocity),
    .controller_id(controller_id),
    .controller_value(controller_value),
    .bend_offset(bend_offset),
    .last_of_run(last_of_run),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic router_event_t make_event(input mmr_pkg::event_kind_t kind,
                                               input int slot,
                                               input int key, input int vel, input int cid,
                                               input int cval, input int bend);
    router_event_t ev;
    ev.kind       = kind;
    ev.slot       = slot[2:0];
    ev.key        = key[8:0];
    ev.velocity   = vel[7:0];
    ev.ctrl_id    = cid[7:0];
    ev.ctrl_value = cval[7:0];
    ev.bend       = bend[15:0];
    ev.last_flag  = 1'b0;
    return ev;
  endfunction

  // parse one accepted byte and queue the slot events it causes
  function automatic void predict_byte(input logic [7:0] b);
    router_event_t run [$];
    router_event_t ev;
    logic [mmr_pkg::ROUTE_W-1:0] w;
    logic signed [3:0] trans;
    logic [7:0] vel;
    int key;
    int bend_v;
    if (b == mmr_pkg::BYTE_CLOCK) begin
      ev = make_event(mmr_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0);
      ev.last_flag = 1'b1;
      expected_events.insert(expected_events.size(), ev);
      return;
    end
    if (phase_copy == mmr_pkg::PH_FIRST) begin
      first_copy = b;
      phase_copy = mmr_pkg::PH_SECOND;
      return;
    end
    if (phase_copy != mmr_pkg::PH_SECOND) begin
      if (b >= mmr_pkg::STATUS_FIRST && b < mmr_pkg::STATUS_SYSTEM) begin
        chan_copy  = b[3:0];
        cmd_copy   = b[7:4];
        phase_copy = mmr_pkg::PH_FIRST;
      end else begin
        phase_copy = mmr_pkg::PH_STATUS;
      end
      return;
    end
    // second data byte completes the message
    vel = (cmd_copy == mmr_pkg::CMD_NOTE_OFF) ? 8'h00 : b;
    bend_v = (int'(first_copy) | (int'(b) << 7)) - int'(mmr_pkg::BEND_CENTER);
    for (int s = 0; s < SLOT_COUNT; s++) begin
      w = route_copy[s];
      trans = w[26:23];
      if (!w[0]) continue;
      if (cmd_copy == mmr_pkg::CMD_NOTE_OFF || cmd_copy == mmr_pkg::CMD_NOTE_ON) begin
        if (w[4:1] == chan_copy && first_copy[6:0] >= 0 && {1'b0, first_copy} >= {2'b0, w[15:9]}
            && {1'b0, first_copy} <= {2'b0, w[22:16]}) begin
          key = int'(first_copy) + int'(trans) * 12;
          if (vel == 8'h00)
            run.insert(run.size(), make_event(mmr_pkg::KIND_STOP, s, key, 0, 0, 0, 0));
          else
            run.insert(run.size(), make_event(mmr_pkg::KIND_PLAY, s, key, int'(vel), 0, 0, 0));
        end
      end else if (cmd_copy == mmr_pkg::CMD_CTRL) begin
        if (w[8:5] == chan_copy)
          run.insert(run.size(),
                     make_event(mmr_pkg::KIND_CTRL, s, 0, 0, int'(first_copy), int'(b), 0));
      end else if (cmd_copy == mmr_pkg::CMD_BEND) begin
        if (w[4:1] == chan_copy)
          run.insert(run.size(), make_event(mmr_pkg::KIND_BEND, s, 0, 0, 0, 0, bend_v));
      end
    end
    phase_copy = mmr_pkg::PH_STATUS;
    if (run.size() > 0) run[run.size() - 1].last_flag = 1'b1;
    foreach (run[i]) expected_events.insert(expected_events.size(), run[i]);
  endfunction

  task automatic compare_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endtask

  // input monitor feeds the predictor, output monitor checks each item
  always @(posedge clk) begin
    router_event_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result item: kind %0d slot %0d", event_kind, slot_index);
          errors++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_kind", int'(want.kind), int'(event_kind));
          compare_field("slot_index", int'(want.slot), int'(slot_index));
          compare_field("out_key", int'(want.key), int'(out_key));
          compare_field("out_velocity", int'(want.velocity), int'(out_velocity));
          compare_field("controller_id", int'(want.ctrl_id), int'(controller_id));
          compare_field("controller_value", int'(want.ctrl_value), int'(controller_value));
          compare_field("bend_offset", int'(want.bend), int'(bend_offset));
          compare_field("last_of_run", int'(want.last_flag), int'(last_of_run));
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [3:0] cmd, input logic [3:0] chan,
                              input logic [7:0] data_a, input logic [7:0] data_b);
    send_byte({cmd, chan});
    send_byte(data_a);
    send_byte(data_b);
  endtask

  // hold the sender until every queued result item has come out
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_route(input int idx, input logic [mmr_pkg::ROUTE_W-1:0] word);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx[mmr_pkg::REG_IDX_W-1:0];
    cfg_data  <= word;
    route_copy[idx] = word;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [mmr_pkg::ROUTE_W-1:0] pack_route(input int en, input int note_ch,
                                                            input int ctrl_ch, input int lo_key,
                                                            input int hi_key, input int trans);
    return {trans[3:0], hi_key[6:0], lo_key[6:0], ctrl_ch[3:0], note_ch[3:0], en[0]};
  endfunction

  // channels cluster on a few values so that routing words match often
  function automatic logic [3:0] pick_channel();
    case ($urandom_range(3))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd15;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [mmr_pkg::ROUTE_W-1:0] random_route_word();
    int lo_key;
    int hi_key;
    if ($urandom_range(9) < 7) begin
      lo_key = $urandom_range(100);
      hi_key = $urandom_range(127, lo_key);
    end else begin
      lo_key = $urandom_range(127);
      hi_key = $urandom_range(127);
    end
    return pack_route(($urandom_range(99) < 80) ? 1 : 0, int'(pick_channel()),
                      int'(pick_channel()), lo_key, hi_key, $urandom_range(15));
  endfunction

  // reset routing: everything disabled, only ticks come out
  task automatic test_clock_and_ignored();
    send_byte(mmr_pkg::BYTE_CLOCK);
    send_byte(8'h45);
    send_byte(mmr_pkg::STATUS_SYSTEM);
    send_byte(8'hFF);
    send_message(mmr_pkg::CMD_NOTE_ON, 4'd0, 8'h3C, 8'h64);
  endtask

  // all slots on channel 0 with different ranges, plus the all-ones word
  task automatic test_directed_routing();
    wait_idle();
    write_route(0, pack_route(1, 0, 0, 0, 127, 0));
    write_route(1, pack_route(1, 0, 1, 60, 72, -8));
    write_route(2, pack_route(1, 0, 0, 0, 127, 7));
    write_route(3, pack_route(1, 0, 0, 100, 50, 0));
    write_route(4, pack_route(0, 0, 0, 0, 127, 0));
    write_route(5, {mmr_pkg::ROUTE_W{1'b1}});
    write_route(6, pack_route(1, 0, 15, 0, 127, 3));
    write_route(7, pack_route(1, 0, 0, 0, 0, -8));
    send_message(mmr_pkg::CMD_NOTE_ON, 4'd0, 8'h00, 8'h7F);
    // clock tick inside a message leaves the parser where it was
    send_byte({mmr_pkg::CMD_NOTE_ON, 4'd0});
    send_byte(mmr_pkg::BYTE_CLOCK);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_message(mmr_pkg::CMD_NOTE_OFF, 4'd0, 8'h3C, 8'h40);
    send_message(mmr_pkg::CMD_NOTE_ON, 4'd0, 8'h40, 8'h00);
    // status values in data positions are plain data
    send_message(mmr_pkg::CMD_CTRL, 4'd0, 8'h90, 8'hFF);
    send_message(mmr_pkg::CMD_BEND, 4'd0, 8'h00, 8'h00);
    send_message(mmr_pkg::CMD_BEND, 4'd15, 8'hFF, 8'hFF);
    send_message(CMD_PROGRAM, 4'd0, 8'h05, 8'h06);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int byte_target, input bit full_fanout,
                                     input bit pause_midway);
    int start_count;
    bit paused;
    int pick;
    logic [3:0] cmd;
    logic [7:0] data_a;
    logic [7:0] data_b;
    wait_idle();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (full_fanout) write_route(i, pack_route(1, 0, $urandom_range(15), 0, 127,
                                                 $urandom_range(15)));
      else write_route(i, random_route_word());
    end
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start_count < byte_target) begin
      if (pause_midway && !paused && bytes_sent - start_count >= byte_target / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_byte(mmr_pkg::BYTE_CLOCK);
      end else if (pick < 12) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0, 1: cmd = mmr_pkg::CMD_NOTE_ON;
          2: cmd = mmr_pkg::CMD_NOTE_OFF;
          3, 4: cmd = mmr_pkg::CMD_CTRL;
          5, 6: cmd = mmr_pkg::CMD_BEND;
          7: cmd = CMD_POLY_PRESSURE;
          8: cmd = CMD_PROGRAM;
          default: cmd = CMD_CHAN_PRESSURE;
        endcase
        data_a = ($urandom_range(3) != 0) ? 8'($urandom_range(127)) : 8'($urandom_range(255));
        data_b = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
        send_byte({cmd, pick_channel()});
        if ($urandom_range(19) == 0) send_byte(mmr_pkg::BYTE_CLOCK);
        send_byte(data_a);
        // broken message: the next byte other than a clock lands in the second data slot
        if ($urandom_range(19) != 0) send_byte(data_b);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) route_copy[i] = '0;
    send_idle_pct = 36;
    recv_idle_pct = 51;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_clock_and_ignored();
    test_directed_routing();
    test_random_traffic(36, 51, 120, 1'b0, 1'b1);
    test_random_traffic(51, 36, 120, 1'b0, 1'b0);
    test_random_traffic(0, 0, 110, 1'b1, 1'b0);

    // drain and let the last byte settle
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
